// ===== design/md4he_pkg.sv =====
// Shared types, constants and step tables for the MD4 hash engine.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package md4he_pkg;

   localparam int unsigned WordW  = 32;
   localparam int unsigned CountW = 61;
   localparam int unsigned StepW  = 6;

   localparam logic [WordW-1:0] InitA = 32'h67452301;
   localparam logic [WordW-1:0] InitB = 32'hefcdab89;
   localparam logic [WordW-1:0] InitC = 32'h98badcfe;
   localparam logic [WordW-1:0] InitD = 32'h10325476;
   localparam logic [WordW-1:0] KRound2 = 32'h5A827999;
   localparam logic [WordW-1:0] KRound3 = 32'h6ED9EBA1;

   localparam logic [StepW-1:0] LastStep = 6'd47;

   // commands from the controller to the datapath
   typedef struct packed {
      logic             byte_wr;  // pack the accepted byte, advance the count
      logic             load;     // copy the chaining value into the working set
      logic             step;     // run one round step
      logic [StepW-1:0] step_idx;
      logic             add;      // add the working set back into the chaining value
      logic             pad;      // 0x80 marker, zero tail, length if it fits
      logic             zlen;     // zero block carrying only the length
      logic             finish;   // hand the digest to the output stage, reset
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic block_full;  // next byte completes a block
      logic pad_long;    // marker lands past byte 55: two padding blocks
      logic out_busy;    // output stage still holds a digest
   } sts_type;

   // message word used by a step
   function automatic logic [3:0] msg_sel(input logic [StepW-1:0] step);
      logic [3:0] i;
      logic [3:0] sel;
      begin
         i = step[3:0];
         case (step[5:4])
            2'd0:    sel = i;
            2'd1:    sel = {i[1:0], i[3:2]};
            2'd2:    sel = {i[0], i[1], i[2], i[3]};
            default: sel = i;
         endcase
         return sel;
      end
   endfunction

   // left rotation of a step
   function automatic logic [4:0] rot_amt(input logic [StepW-1:0] step);
      logic [4:0] s;
      begin
         case ({step[5:4], step[1:0]})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
         endcase
         return s;
      end
   endfunction

endpackage

// ===== design/md4he_ctrl.sv =====
// Sequencer of the MD4 hash engine: input handshake, compression and
// padding order, digest hand-off. Depends on md4he_pkg.
`timescale 1ns / 1ps

module md4he_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  logic                req_tlast,
   input  md4he_pkg::sts_type  sts,
   output md4he_pkg::cmd_type  cmd
);
   import md4he_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StLoad  = 3'd1;
   localparam logic [2:0] StRound = 3'd2;
   localparam logic [2:0] StAdd   = 3'd3;
   localparam logic [2:0] StPad   = 3'd4;
   localparam logic [2:0] StZlen  = 3'd5;
   localparam logic [2:0] StDone  = 3'd6;

   localparam logic [1:0] KindData  = 2'd0;
   localparam logic [1:0] KindPad1  = 2'd1;
   localparam logic [1:0] KindFinal = 2'd2;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic             end_pend_ff, end_pend_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             accept;

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      end_pend_in = end_pend_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.step_idx = step_ff;
      case (state_ff)
         StIdle: begin
            cmd.byte_wr = accept & req_tuser;
            if (accept) begin
               if (req_tuser && sts.block_full) begin
                  kind_in     = KindData;
                  end_pend_in = req_tlast;
                  state_in    = StLoad;
               end else if (req_tlast) begin
                  state_in = StPad;
               end
            end
         end
         StLoad: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = StRound;
         end
         StRound: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == LastStep) state_in = StAdd;
         end
         StAdd: begin
            cmd.add = 1'b1;
            case (kind_ff)
               KindData:  state_in = end_pend_ff ? StPad : StIdle;
               KindPad1:  state_in = StZlen;
               KindFinal: state_in = StDone;
               default:   state_in = StIdle;
            endcase
         end
         StPad: begin
            cmd.pad  = 1'b1;
            kind_in  = sts.pad_long ? KindPad1 : KindFinal;
            state_in = StLoad;
         end
         StZlen: begin
            cmd.zlen = 1'b1;
            kind_in  = KindFinal;
            state_in = StLoad;
         end
         StDone: begin
            // hold until the previous digest has left
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         kind_ff     <= KindData;
         end_pend_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         end_pend_ff <= end_pend_in;
         step_ff     <= step_in;
      end
   end

endmodule

// ===== design/md4he_dp.sv =====
// Datapath of the MD4 hash engine: block buffer, byte count, chaining value,
// one round step per cycle and the digest output stage. Depends on md4he_pkg.
`timescale 1ns / 1ps

module md4he_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_tdata,
   input  md4he_pkg::cmd_type  cmd,
   output md4he_pkg::sts_type  sts,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import md4he_pkg::*;

   logic [WordW-1:0]  blk_ff [16];
   logic [WordW-1:0]  blk_in [16];
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [WordW-1:0]  cv_ff [4];
   logic [WordW-1:0]  cv_in [4];
   logic [WordW-1:0]  va_ff, vb_ff, vc_ff, vd_ff;
   logic [WordW-1:0]  dig_ff [4];
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_idx_ff, out_idx_in;

   logic [3:0]        wsel;
   logic [1:0]        lane;
   logic [63:0]       bit_len;
   logic [WordW-1:0]  fval, kval, xval, sum, rot_new;
   logic [63:0]       rot_dbl;

   function automatic logic [WordW-1:0] put_byte(input logic [WordW-1:0] old,
                                                 input logic [1:0] ln,
                                                 input logic [7:0] b);
      logic [WordW-1:0] r;
      begin
         if (ln == 2'd0) r = {24'b0, b};
         else r = old | ({24'b0, b} << {ln, 3'b000});
         return r;
      end
   endfunction

   assign wsel    = cnt_ff[5:2];
   assign lane    = cnt_ff[1:0];
   assign bit_len = {cnt_ff, 3'b000};

   assign sts.block_full = (cnt_ff[5:0] == 6'd63);
   assign sts.pad_long   = (cnt_ff[5:0] >= 6'd56);
   assign sts.out_busy   = out_valid_ff;

   // block buffer and byte count
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < 16; i++) blk_in[i] = blk_ff[i];
      if (cmd.byte_wr) begin
         blk_in[wsel] = put_byte(blk_ff[wsel], lane, req_tdata);
         cnt_in       = cnt_ff + 1'b1;
      end
      if (cmd.pad) begin
         for (int i = 0; i < 16; i++) begin
            if (4'(i) == wsel) blk_in[i] = put_byte(blk_ff[i], lane, 8'h80);
            else if (4'(i) > wsel) blk_in[i] = '0;
         end
         if (!sts.pad_long) begin
            blk_in[14] = bit_len[31:0];
            blk_in[15] = bit_len[63:32];
         end
      end
      if (cmd.zlen) begin
         for (int i = 0; i < 14; i++) blk_in[i] = '0;
         blk_in[14] = bit_len[31:0];
         blk_in[15] = bit_len[63:32];
      end
      if (cmd.finish) cnt_in = '0;
   end

   // one MD4 step: rotl(a + f(b,c,d) + x + k, s), then rotate the working set
   always_comb begin
      case (cmd.step_idx[5:4])
         2'd0: begin
            fval = (vb_ff & vc_ff) | (~vb_ff & vd_ff);
            kval = '0;
         end
         2'd1: begin
            fval = (vb_ff & vc_ff) | (vb_ff & vd_ff) | (vc_ff & vd_ff);
            kval = KRound2;
         end
         default: begin
            fval = vb_ff ^ vc_ff ^ vd_ff;
            kval = KRound3;
         end
      endcase
      xval    = blk_ff[msg_sel(cmd.step_idx)];
      sum     = va_ff + fval + xval + kval;
      rot_dbl = {sum, sum} << rot_amt(cmd.step_idx);
      rot_new = rot_dbl[63:32];
   end

   always_comb begin
      for (int i = 0; i < 4; i++) cv_in[i] = cv_ff[i];
      if (cmd.add) begin
         cv_in[0] = cv_ff[0] + va_ff;
         cv_in[1] = cv_ff[1] + vb_ff;
         cv_in[2] = cv_ff[2] + vc_ff;
         cv_in[3] = cv_ff[3] + vd_ff;
      end
      if (cmd.finish) begin
         cv_in[0] = InitA;
         cv_in[1] = InitB;
         cv_in[2] = InitC;
         cv_in[3] = InitD;
      end
   end

   // output stage: four beats, A first
   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      if (rsp_tvalid && rsp_tready) begin
         out_idx_in = out_idx_ff + 1'b1;
         if (out_idx_ff == 2'd3) out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_idx_in   = '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = dig_ff[out_idx_ff];
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cv_ff[0]     <= InitA;
         cv_ff[1]     <= InitB;
         cv_ff[2]     <= InitC;
         cv_ff[3]     <= InitD;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         for (int i = 0; i < 4; i++) cv_ff[i] <= cv_in[i];
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) blk_ff[i] <= blk_in[i];
      if (cmd.load) begin
         va_ff <= cv_ff[0];
         vb_ff <= cv_ff[1];
         vc_ff <= cv_ff[2];
         vd_ff <= cv_ff[3];
      end else if (cmd.step) begin
         va_ff <= vd_ff;
         vb_ff <= rot_new;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      if (cmd.finish) begin
         for (int i = 0; i < 4; i++) dig_ff[i] <= cv_ff[i];
      end
   end

endmodule

// ===== design/md4_hash_engine_unit.sv =====
// MD4 hash engine, byte-serial message digest.
// Request channel: one beat per item. req_tdata = data_byte, req_tuser =
//   byte_present, req_tlast = end_of_message. A beat with req_tuser low and
//   req_tlast low is idle and changes nothing.
// Response channel: four beats per message, digest words A, B, C, D.
//   rsp_tdata = digest_word, rsp_tuser = word_index, rsp_tlast on word D.
// Byte beats are taken while idle. A beat that completes a 64-byte
//   block holds req_tready low through the load, the 48 round steps on one
//   shared step unit and the feed-forward add.
// The end beat is followed by a padding step and the compression of the last
//   block, plus a length-only block and its compression if the length word
//   needs a second padding block, then by the hand-off of the digest to the
//   output register; the first digest beat appears the cycle after that.
// The digest sits in its own output register, so a stalled response side
//   does not stop byte beats; only the hand-off of the next digest waits
//   until all four beats of the previous one have been taken.
// Reset (synchronous, active high) loads the MD4 initial chaining value,
//   clears the byte count and drops any digest not yet taken.
// Depends on md4he_pkg, md4he_ctrl and md4he_dp.
`timescale 1ns / 1ps

module md4_hash_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast
);
   import md4he_pkg::*;

   cmd_type cmd;
   sts_type sts;

   md4he_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   md4he_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/md4_digest_checker.sv =====
// Watches the request and response channels of the MD4 hash engine, predicts each digest
// and compares every response beat against it.
// Depends on md4he_pkg for the initial chaining value and the round constants.
`timescale 1ns / 1ps

module md4_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] digest_word
   input  logic [1:0]  rsp_tuser,   // [1:0] word_index
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          digests_pending
);
   import md4he_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  idx;
      logic        last;
   } digest_beat_type;

   // left-rotate amounts per lane, lane 0 in the lowest five bits
   localparam logic [19:0] Round1Shift = {5'd19, 5'd11, 5'd7, 5'd3};
   localparam logic [19:0] Round2Shift = {5'd13, 5'd9, 5'd5, 5'd3};
   localparam logic [19:0] Round3Shift = {5'd15, 5'd11, 5'd9, 5'd3};

   logic [31:0]     chain [4];
   logic [31:0]     block [16];
   logic [60:0]     byte_count;
   digest_beat_type digest_q [$];
   int              err_count = 0;

   assign mismatches = err_count;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void compress_block();
      logic [31:0] v [4];
      logic [31:0] b, c, d, f, k, m;
      int unsigned t, s, j, w;
      for (int n = 0; n < 4; n++) v[n] = chain[n];
      for (int unsigned i = 0; i < 48; i++) begin
         // target lane walks a, d, c, b
         t = (4 - (i % 4)) % 4;
         b = v[(t + 1) % 4];
         c = v[(t + 2) % 4];
         d = v[(t + 3) % 4];
         j = i % 16;
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               k = '0;
               w = j;
               s = 32'(Round1Shift[5 * (i % 4) +: 5]);
            end
            1: begin
               f = (b & c) | (b & d) | (c & d);
               k = KRound2;
               w = ((j & 3) << 2) | (j >> 2);
               s = 32'(Round2Shift[5 * (i % 4) +: 5]);
            end
            default: begin
               f = b ^ c ^ d;
               k = KRound3;
               // bit-reversed word order
               w = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
               s = 32'(Round3Shift[5 * (i % 4) +: 5]);
            end
         endcase
         m = block[w];
         v[t] = rotl32(v[t] + f + k + m, s);
      end
      for (int n = 0; n < 4; n++) chain[n] = chain[n] + v[n];
   endfunction

   function automatic void pack_byte(input int unsigned pos, input logic [7:0] val);
      int unsigned w;
      w = (pos >> 2) & 15;
      if ((pos & 3) == 0)
         block[w] = {24'd0, val};
      else
         block[w] = block[w] | ({24'd0, val} << (8 * (pos & 3)));
   endfunction

   function automatic void load_iv();
      chain[0] = InitA;
      chain[1] = InitB;
      chain[2] = InitC;
      chain[3] = InitD;
      byte_count = '0;
   endfunction

   // pad, run the closing block(s), queue the four digest beats, restart
   function automatic void close_message();
      logic [63:0]     bit_len;
      int unsigned     pos;
      digest_beat_type beat;
      bit_len = {byte_count, 3'b000};
      pos = 32'(byte_count[5:0]);
      pack_byte(pos, 8'h80);
      pos++;
      if (pos > 56) begin
         while (pos < 64) begin
            pack_byte(pos, 8'h00);
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         pack_byte(pos, 8'h00);
         pos++;
      end
      block[14] = bit_len[31:0];
      block[15] = bit_len[63:32];
      compress_block();
      for (int n = 0; n < 4; n++) begin
         beat.word = chain[n];
         beat.idx  = n[1:0];
         beat.last = (n == 3);
         digest_q.insert(digest_q.size(), beat);
      end
      load_iv();
   endfunction

   function automatic void take_request(input logic [7:0] val, input logic present,
                                        input logic last);
      if (present) begin
         pack_byte(32'(byte_count[5:0]), val);
         byte_count = byte_count + 1'b1;
         if (byte_count[5:0] == 6'd0) compress_block();
      end
      if (last) close_message();
   endfunction

   function automatic void check_response();
      digest_beat_type want;
      if (digest_q.size() == 0) begin
         err_count++;
         if (err_count <= 10)
            $display("%0t: unexpected digest beat word %h idx %0d last %b",
                     $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = digest_q.pop_front();
         if (rsp_tdata !== want.word || rsp_tuser !== want.idx || rsp_tlast !== want.last) begin
            err_count++;
            if (err_count <= 10)
               $display("%0t: digest beat: expected word %h idx %0d last %b, got %h %0d %b",
                        $realtime, want.word, want.idx, want.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         load_iv();
         for (int n = 0; n < 16; n++) block[n] = '0;
         digest_q.delete();
      end else begin
         if (req_tvalid && req_tready) take_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) check_response();
      end
      digests_pending <= digest_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the MD4 hash engine testbench: clock, reset, message stimulus and the verdict.
// Depends on md4_hash_engine_unit and md4_digest_checker.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned StallLimit = 3000;
   localparam int unsigned ItemTarget = 280;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tuser = 1'b0; // [0] byte_present
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [31:0] digest_word
   logic [1:0]  rsp_tuser;       // [1:0] word_index
   logic        rsp_tlast;

   int          mismatches;
   int          digests_pending;
   logic        steady = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent = 0;

   md4_hash_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   md4_digest_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .digests_pending (digests_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 18);
   end

   // end the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] val, input logic present, input logic last);
      while (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (present || last) items_sent++;
   endtask

   // hold the sender until every queued digest beat has been taken
   task automatic drain_digests();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (digests_pending != 0);
   endtask

   task automatic send_message(input int unsigned len);
      logic end_on_byte;
      end_on_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int unsigned n = 0; n < len; n++) begin
         // sprinkle in ignored beats
         if ($urandom_range(99) < 6) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (n == len - 1));
      end
      if (!end_on_byte) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return $urandom_range(12);
      if (r < 80) return $urandom_range(70, 50);   // around the padding split
      if (r < 95) return $urandom_range(49, 13);
      return $urandom_range(135, 110);
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: idle beats, empty message, single bytes at the extremes, "abc"
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hA5, 1'b0, 1'b1);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      // back-to-back empty messages
      send_beat(8'h5A, 1'b0, 1'b1);
      send_beat(8'hC3, 1'b0, 1'b1);
      drain_digests();

      // length field needs a second padding block, then just fits
      steady <= 1'b1;
      send_message(56);
      steady <= 1'b0;
      send_message(55);
      drain_digests();

      while (items_sent < ItemTarget) send_message(pick_length());
      drain_digests();

      repeat (120) @(posedge clock);
      if (mismatches == 0 && digests_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
